[sv/gmn_pkg.sv]
// ----------------------------------------------------------------------------
// gmn_pkg
// Types and constants shared by the grid mesh normal and texcoord block.
// ----------------------------------------------------------------------------
package gmn_pkg;

  localparam int COORD_W   = 24;
  localparam int IDX_W     = 7;
  localparam int NORM_W    = 16;
  localparam int TEX_W     = 17;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int MUL_W   = 31;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CROSS_W = 2 * DIFF_W + 1;
  localparam int AA_W    = CROSS_W;
  localparam int UNIT_W  = 30;
  localparam int SUM_W   = 2 * UNIT_W + 2;
  localparam int ROOT_W  = UNIT_W + 1;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int Q_W     = 17;
  localparam int NUM_W   = UNIT_W + 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_R = 2'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                      kind;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
    logic                      degenerate;
  } out_item_t;

endpackage

[sv/grid_mesh_normal_texcoord.sv]
// ----------------------------------------------------------------------------
// grid_mesh_normal_texcoord
// Grid of 3D points with central-difference unit normals and texcoords.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// input    | start, busy          | in_item  (gmn_pkg::in_item_t)
// result   | out_valid (1 cycle)  | out_item (gmn_pkg::out_item_t)
// config   | cfg_we               | cfg_index, cfg_data
//
// A load leaves busy low. A query holds busy while the bit-serial square
// root and five passes of the shared restoring divider run; a degenerate
// normal skips three of the divider passes. The result strobe comes in the
// same cycle that busy drops. Reset is synchronous; the point store has no
// reset.
// ----------------------------------------------------------------------------
module grid_mesh_normal_texcoord #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  gmn_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [gmn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmn_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  output gmn_pkg::out_item_t                  out_item
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RW     = ($clog2(MAX_ROWS + 2) > gmn_pkg::IDX_W) ?
                          $clog2(MAX_ROWS + 2) : gmn_pkg::IDX_W;
  localparam int CLW    = ($clog2(MAX_COLS + 2) > gmn_pkg::IDX_W) ?
                          $clog2(MAX_COLS + 2) : gmn_pkg::IDX_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_READ = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_MAG  = 8'b0000_1000,
    S_NORM = 8'b0001_0000,
    S_SQ   = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_DIV  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [gmn_pkg::CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic                      wrap_c_r, wrap_r_r;

  gmn_pkg::point_t mem [DEPTH];
  gmn_pkg::point_t rd_data_r;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              mem_we;

  logic [2:0] cnt_r;
  logic [RW-1:0]  r_r, pr_r, nrn_r;
  logic [CLW-1:0] c_r, pc_r, ncn_r;
  logic [RW-1:0]  rcount_r;
  logic [CLW-1:0] ccount_r;
  logic [gmn_pkg::IDX_W-1:0] row_f_r, col_f_r;

  gmn_pkg::point_t cell_r, pa_r;
  logic signed [gmn_pkg::DIFF_W-1:0] du_r [3];
  logic signed [gmn_pkg::DIFF_W-1:0] dv_r [3];
  logic signed [gmn_pkg::CROSS_W-1:0] cr_r [3];
  logic [gmn_pkg::AA_W-1:0] aa_r [3];
  logic [2:0] neg_r;
  logic       degen_r;

  logic signed [gmn_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [gmn_pkg::PROD_W-1:0] prod_r;

  logic [gmn_pkg::SUM_W-1:0] sum_r, rn_r, root_r, bit_r;
  logic [gmn_pkg::SUM_W-1:0] trial;

  logic [2:0]  job_r;
  logic [4:0]  dcnt_r;
  logic [gmn_pkg::DEN_W-1:0] rem_r, den_r;
  logic [gmn_pkg::Q_W-1:0]   dnum_r, q_r;
  logic [gmn_pkg::DEN_W:0]   rem2;
  logic                      ge;
  logic [gmn_pkg::Q_W-1:0]   q_nxt;
  logic [gmn_pkg::NUM_W-1:0] setup_num;
  logic [gmn_pkg::DEN_W-1:0] setup_den;
  logic                      setup_skip;

  logic signed [gmn_pkg::NORM_W-1:0] nx_r, ny_r, nz_r;
  logic [gmn_pkg::TEX_W-1:0]         tu_r, tv_r;
  logic [gmn_pkg::NORM_W-1:0]        nq;

  logic                out_valid_r;
  gmn_pkg::out_item_t  out_item_r;

  logic [RW-1:0]  rowx, nr, nrw, r_q, pr_q, nrn_q;
  logic [CLW-1:0] colx, nc, ncw, c_q, pc_q, ncn_q;
  logic           accept, q_ok;
  logic [RW-1:0]  ar;
  logic [CLW-1:0] ac;
  logic [gmn_pkg::AA_W-1:0] orv;
  logic [gmn_pkg::UNIT_W-1:0] aa_sel;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // query geometry
  always_comb begin
    rowx = RW'(in_item.row);
    colx = CLW'(in_item.col);
    if (rows_cfg_r == '0) nr = RW'(1);
    else if (RW'(rows_cfg_r) > RW'(MAX_ROWS)) nr = RW'(MAX_ROWS);
    else nr = RW'(rows_cfg_r);
    if (cols_cfg_r == '0) nc = CLW'(1);
    else if (CLW'(cols_cfg_r) > CLW'(MAX_COLS)) nc = CLW'(MAX_COLS);
    else nc = CLW'(cols_cfg_r);
    nrw  = nr + RW'(wrap_r_r);
    ncw  = nc + CLW'(wrap_c_r);
    q_ok = (rowx < nrw) && (colx < ncw);
    r_q  = (rowx >= nr) ? '0 : rowx;
    c_q  = (colx >= nc) ? '0 : colx;
    pc_q  = (c_q == '0) ? (wrap_c_r ? nc - CLW'(1) : c_q) : c_q - CLW'(1);
    ncn_q = (c_q == nc - CLW'(1)) ? (wrap_c_r ? '0 : c_q) : c_q + CLW'(1);
    pr_q  = (r_q == '0) ? (wrap_r_r ? nr - RW'(1) : r_q) : r_q - RW'(1);
    nrn_q = (r_q == nr - RW'(1)) ? (wrap_r_r ? '0 : r_q) : r_q + RW'(1);
  end

  // store access
  assign mem_we  = accept && (in_item.kind == gmn_pkg::KIND_LOAD) &&
                   (rowx < RW'(MAX_ROWS)) && (colx < CLW'(MAX_COLS));
  assign wr_addr = ADDR_W'(int'(rowx) * MAX_COLS + int'(colx));

  always_comb begin
    unique case (cnt_r)
      3'd1:    begin ar = r_r;   ac = ncn_r; end
      3'd2:    begin ar = r_r;   ac = pc_r;  end
      3'd3:    begin ar = nrn_r; ac = c_r;   end
      3'd4:    begin ar = pr_r;  ac = c_r;   end
      default: begin ar = r_r;   ac = c_r;   end
    endcase
    rd_addr = ADDR_W'(int'(ar) * MAX_COLS + int'(ac));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{x: in_item.pos_x, y: in_item.pos_y, z: in_item.pos_z};
    end
    rd_data_r <= mem[rd_addr];
  end

  // shared multiplier
  always_comb begin
    aa_sel = aa_r[0][gmn_pkg::UNIT_W-1:0];
    mul_a  = '0;
    mul_b  = '0;
    if (state_r == S_SQ) begin
      case (cnt_r)
        3'd1:    aa_sel = aa_r[1][gmn_pkg::UNIT_W-1:0];
        3'd2:    aa_sel = aa_r[2][gmn_pkg::UNIT_W-1:0];
        default: aa_sel = aa_r[0][gmn_pkg::UNIT_W-1:0];
      endcase
      mul_a = gmn_pkg::MUL_W'(aa_sel);
      mul_b = gmn_pkg::MUL_W'(aa_sel);
    end else begin
      case (cnt_r)
        3'd0: begin mul_a = gmn_pkg::MUL_W'(dv_r[1]); mul_b = gmn_pkg::MUL_W'(du_r[2]); end
        3'd1: begin mul_a = gmn_pkg::MUL_W'(dv_r[2]); mul_b = gmn_pkg::MUL_W'(du_r[1]); end
        3'd2: begin mul_a = gmn_pkg::MUL_W'(dv_r[2]); mul_b = gmn_pkg::MUL_W'(du_r[0]); end
        3'd3: begin mul_a = gmn_pkg::MUL_W'(dv_r[0]); mul_b = gmn_pkg::MUL_W'(du_r[2]); end
        3'd4: begin mul_a = gmn_pkg::MUL_W'(dv_r[0]); mul_b = gmn_pkg::MUL_W'(du_r[1]); end
        3'd5: begin mul_a = gmn_pkg::MUL_W'(dv_r[1]); mul_b = gmn_pkg::MUL_W'(du_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign orv   = aa_r[0] | aa_r[1] | aa_r[2];
  assign trial = root_r + bit_r;

  // divider step and job setup
  always_comb begin
    rem2  = {rem_r, dnum_r[gmn_pkg::Q_W-1]};
    ge    = rem2 >= {1'b0, den_r};
    q_nxt = {q_r[gmn_pkg::Q_W-2:0], ge};
    setup_skip = 1'b0;
    setup_num  = '0;
    setup_den  = '0;
    case (job_r)
      3'd3: begin
        setup_skip = (ccount_r <= CLW'(1));
        setup_num  = (gmn_pkg::NUM_W'(col_f_r) << 17) +
                     gmn_pkg::NUM_W'(ccount_r - CLW'(1));
        setup_den  = gmn_pkg::DEN_W'(ccount_r - CLW'(1)) << 1;
      end
      3'd4: begin
        setup_skip = (rcount_r <= RW'(1));
        setup_num  = (gmn_pkg::NUM_W'(row_f_r) << 17) +
                     gmn_pkg::NUM_W'(rcount_r - RW'(1));
        setup_den  = gmn_pkg::DEN_W'(rcount_r - RW'(1)) << 1;
      end
      default: begin
        setup_num = (gmn_pkg::NUM_W'(aa_sel_div(job_r)) << 15) +
                    gmn_pkg::NUM_W'(root_r[gmn_pkg::ROOT_W-1:0]);
        setup_den = {root_r[gmn_pkg::ROOT_W-1:0], 1'b0};
      end
    endcase
    nq = q_nxt[gmn_pkg::NORM_W-1:0];
    case (job_r)
      3'd0: if (neg_r[0]) nq = gmn_pkg::NORM_W'(0) - q_nxt[gmn_pkg::NORM_W-1:0];
      3'd1: if (neg_r[1]) nq = gmn_pkg::NORM_W'(0) - q_nxt[gmn_pkg::NORM_W-1:0];
      3'd2: if (neg_r[2]) nq = gmn_pkg::NORM_W'(0) - q_nxt[gmn_pkg::NORM_W-1:0];
      default: nq = q_nxt[gmn_pkg::NORM_W-1:0];
    endcase
  end

  function automatic logic [gmn_pkg::UNIT_W-1:0] aa_sel_div(input logic [2:0] j);
    logic [gmn_pkg::UNIT_W-1:0] v;
    case (j)
      3'd1:    v = aa_r[1][gmn_pkg::UNIT_W-1:0];
      3'd2:    v = aa_r[2][gmn_pkg::UNIT_W-1:0];
      default: v = aa_r[0][gmn_pkg::UNIT_W-1:0];
    endcase
    return v;
  endfunction

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && in_item.kind == gmn_pkg::KIND_QUERY && q_ok) state_nxt = S_READ;
      S_READ: if (cnt_r == 3'd5) state_nxt = S_MUL;
      S_MUL:  if (cnt_r == 3'd6) state_nxt = S_MAG;
      S_MAG:  state_nxt = ((cr_r[0] | cr_r[1] | cr_r[2]) == '0) ? S_DIV : S_NORM;
      S_NORM: if ((orv >> 29) == gmn_pkg::AA_W'(1)) state_nxt = S_SQ;
      S_SQ:   if (cnt_r == 3'd4) state_nxt = S_ROOT;
      S_ROOT: if (bit_r[0]) state_nxt = S_DIV;
      S_DIV: begin
        if (job_r == 3'd4 && ((dcnt_r == 5'd0 && setup_skip) ||
                              dcnt_r == 5'(gmn_pkg::Q_W))) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      job_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      rows_cfg_r  <= gmn_pkg::CFG_W'(64);
      cols_cfg_r  <= gmn_pkg::CFG_W'(64);
      wrap_c_r    <= 1'b0;
      wrap_r_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          gmn_pkg::CFG_ROWS:   rows_cfg_r <= cfg_data;
          gmn_pkg::CFG_COLS:   cols_cfg_r <= cfg_data;
          gmn_pkg::CFG_WRAP_C: wrap_c_r   <= cfg_data[0];
          gmn_pkg::CFG_WRAP_R: wrap_r_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: cnt_r <= '0;
        S_READ: cnt_r <= (cnt_r == 3'd5) ? 3'd0 : cnt_r + 3'd1;
        S_MUL:  cnt_r <= (cnt_r == 3'd6) ? 3'd0 : cnt_r + 3'd1;
        S_MAG: begin
          cnt_r  <= '0;
          dcnt_r <= '0;
          job_r  <= ((cr_r[0] | cr_r[1] | cr_r[2]) == '0) ? 3'd3 : 3'd0;
        end
        S_NORM: cnt_r <= '0;
        S_SQ:   cnt_r <= cnt_r + 3'd1;
        S_ROOT: begin
          cnt_r  <= '0;
          dcnt_r <= '0;
        end
        S_DIV: begin
          if ((dcnt_r == 5'd0 && setup_skip) || dcnt_r == 5'(gmn_pkg::Q_W)) begin
            dcnt_r <= '0;
            job_r  <= job_r + 3'd1;
            if (job_r == 3'd4) out_valid_r <= 1'b1;
          end else begin
            dcnt_r <= dcnt_r + 5'd1;
          end
        end
        default: cnt_r <= '0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        r_r <= r_q;  c_r <= c_q;  pr_r <= pr_q;  nrn_r <= nrn_q;
        pc_r <= pc_q;  ncn_r <= ncn_q;
        rcount_r <= nrw;  ccount_r <= ncw;
        row_f_r <= in_item.row;  col_f_r <= in_item.col;
      end
      S_READ: begin
        case (cnt_r)
          3'd1: cell_r <= rd_data_r;
          3'd2: pa_r   <= rd_data_r;
          3'd3: begin
            du_r[0] <= gmn_pkg::DIFF_W'(pa_r.x) - gmn_pkg::DIFF_W'(rd_data_r.x);
            du_r[1] <= gmn_pkg::DIFF_W'(pa_r.y) - gmn_pkg::DIFF_W'(rd_data_r.y);
            du_r[2] <= gmn_pkg::DIFF_W'(pa_r.z) - gmn_pkg::DIFF_W'(rd_data_r.z);
          end
          3'd4: pa_r <= rd_data_r;
          3'd5: begin
            dv_r[0] <= gmn_pkg::DIFF_W'(pa_r.x) - gmn_pkg::DIFF_W'(rd_data_r.x);
            dv_r[1] <= gmn_pkg::DIFF_W'(pa_r.y) - gmn_pkg::DIFF_W'(rd_data_r.y);
            dv_r[2] <= gmn_pkg::DIFF_W'(pa_r.z) - gmn_pkg::DIFF_W'(rd_data_r.z);
          end
          default: ;
        endcase
      end
      S_MUL: begin
        case (cnt_r)
          3'd1: cr_r[0] <= gmn_pkg::CROSS_W'(prod_r);
          3'd2: cr_r[0] <= cr_r[0] - gmn_pkg::CROSS_W'(prod_r);
          3'd3: cr_r[1] <= gmn_pkg::CROSS_W'(prod_r);
          3'd4: cr_r[1] <= cr_r[1] - gmn_pkg::CROSS_W'(prod_r);
          3'd5: cr_r[2] <= gmn_pkg::CROSS_W'(prod_r);
          3'd6: cr_r[2] <= cr_r[2] - gmn_pkg::CROSS_W'(prod_r);
          default: ;
        endcase
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cr_r[i][gmn_pkg::CROSS_W-1];
          aa_r[i]  <= cr_r[i][gmn_pkg::CROSS_W-1] ? gmn_pkg::AA_W'(-cr_r[i]) :
                                                    gmn_pkg::AA_W'(cr_r[i]);
        end
        degen_r <= ((cr_r[0] | cr_r[1] | cr_r[2]) == '0);
        nx_r <= '0;  ny_r <= '0;  nz_r <= '0;
      end
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if ((orv >> 38) != '0)      aa_r[i] <= aa_r[i] >> 8;
          else if ((orv >> 30) != '0) aa_r[i] <= aa_r[i] >> 1;
          else if ((orv >> 21) == '0) aa_r[i] <= aa_r[i] << 8;
          else if ((orv >> 29) == '0) aa_r[i] <= aa_r[i] << 1;
        end
      end
      S_SQ: begin
        if (cnt_r == 3'd0) sum_r <= '0;
        else sum_r <= sum_r + gmn_pkg::SUM_W'(prod_r);
        rn_r   <= sum_r;
        root_r <= '0;
        bit_r  <= gmn_pkg::SUM_W'(1) << (2 * (gmn_pkg::UNIT_W));
      end
      S_ROOT: begin
        if (rn_r >= trial) begin
          rn_r   <= rn_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_DIV: begin
        if (dcnt_r == 5'd0) begin
          rem_r  <= gmn_pkg::DEN_W'(setup_num >> gmn_pkg::Q_W);
          dnum_r <= setup_num[gmn_pkg::Q_W-1:0];
          den_r  <= setup_den;
          q_r    <= '0;
          if (setup_skip) begin
            if (job_r == 3'd3) tu_r <= '0;
            else               tv_r <= '0;
          end
        end else begin
          rem_r  <= ge ? gmn_pkg::DEN_W'(rem2 - {1'b0, den_r}) :
                         gmn_pkg::DEN_W'(rem2);
          dnum_r <= dnum_r << 1;
          q_r    <= q_nxt;
          if (dcnt_r == 5'(gmn_pkg::Q_W)) begin
            case (job_r)
              3'd0:    nx_r <= nq;
              3'd1:    ny_r <= nq;
              3'd2:    nz_r <= nq;
              3'd3:    tu_r <= q_nxt;
              default: tv_r <= q_nxt;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item_r.out_x      = cell_r.x;
    out_item_r.out_y      = cell_r.y;
    out_item_r.out_z      = cell_r.z;
    out_item_r.normal_x   = nx_r;
    out_item_r.normal_y   = ny_r;
    out_item_r.normal_z   = nz_r;
    out_item_r.tex_u      = tu_r;
    out_item_r.tex_v      = tv_r;
    out_item_r.degenerate = degen_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[sv/gmn_checker.sv]
// ----------------------------------------------------------------------------
// gmn_checker
// Port-level checks for the grid mesh normal and texcoord block.
// ----------------------------------------------------------------------------
module gmn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input gmn_pkg::in_item_t  in_item,
  input logic               out_valid,
  input gmn_pkg::out_item_t out_item
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block active after reset");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result shown while still busy");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.kind == gmn_pkg::KIND_LOAD |=> !busy && !out_valid)
    else $error("load item caused work or a result");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |->
      out_item.normal_x == '0 && out_item.normal_y == '0 && out_item.normal_z == '0)
    else $error("degenerate result with nonzero normal");

endmodule

bind grid_mesh_normal_texcoord gmn_checker u_gmn_checker (.*);

[tb/grid_mesh_normal_texcoord_test.sv]
// ----------------------------------------------------------------------------
// grid_mesh_normal_texcoord_test
// Loads grids of points, queries mesh cells under several row/column and wrap
// settings, and checks position, normal, texcoords and the degenerate flag of
// every result against a cycle-free predictor of the cell computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_mesh_normal_texcoord_test;
  import gmn_pkg::*;

  localparam int GRID = 64;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic out_valid;
  out_item_t out_item;

  grid_mesh_normal_texcoord DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_item(out_item)
  );

  longint grid_x [GRID][GRID];
  longint grid_y [GRID][GRID];
  longint grid_z [GRID][GRID];
  int unsigned set_rows, set_cols;
  bit set_wrap_c, set_wrap_r;
  out_item_t pending_cells[$];
  int errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("grid_mesh_normal_texcoord: mismatch");
    $finish;
  end

  function automatic int unsigned clamp_count(int unsigned v);
    if (v < 1) return 1;
    return (v > GRID) ? GRID : v;
  endfunction

  function automatic int unsigned bit_length(longint unsigned v);
    int unsigned n;
    n = 0;
    while (v != 0) begin
      n++;
      v = v >> 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [TEX_W-1:0] tex_coord(int unsigned idx, int unsigned count);
    longint unsigned d;
    if (count <= 1) return '0;
    d = count - 1;
    return TEX_W'((longint'(idx) * 131072 + d) / (2 * d));
  endfunction

  function automatic bit mesh_cell(input int unsigned row, input int unsigned col,
                                   output out_item_t res);
    int unsigned nr, nc, r, c, pc, ncn, pr, nrn, bl;
    longint du[3], dv[3], cr[3];
    longint unsigned mg[3], aa[3], orv, s, len, q;
    nr = clamp_count(set_rows);
    nc = clamp_count(set_cols);
    res = '0;
    if (row >= nr + set_wrap_r || col >= nc + set_wrap_c) return 1'b0;
    r = (row >= nr) ? 0 : row;
    c = (col >= nc) ? 0 : col;
    pc  = (c == 0) ? (set_wrap_c ? nc - 1 : c) : c - 1;
    ncn = (c == nc - 1) ? (set_wrap_c ? 0 : c) : c + 1;
    pr  = (r == 0) ? (set_wrap_r ? nr - 1 : r) : r - 1;
    nrn = (r == nr - 1) ? (set_wrap_r ? 0 : r) : r + 1;
    du[0] = grid_x[r][ncn] - grid_x[r][pc];
    du[1] = grid_y[r][ncn] - grid_y[r][pc];
    du[2] = grid_z[r][ncn] - grid_z[r][pc];
    dv[0] = grid_x[nrn][c] - grid_x[pr][c];
    dv[1] = grid_y[nrn][c] - grid_y[pr][c];
    dv[2] = grid_z[nrn][c] - grid_z[pr][c];
    cr[0] = dv[1] * du[2] - dv[2] * du[1];
    cr[1] = dv[2] * du[0] - dv[0] * du[2];
    cr[2] = dv[0] * du[1] - dv[1] * du[0];
    orv = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (cr[i] < 0) ? -cr[i] : cr[i];
      orv |= mg[i];
    end
    res.out_x = grid_x[r][c][COORD_W-1:0];
    res.out_y = grid_y[r][c][COORD_W-1:0];
    res.out_z = grid_z[r][c][COORD_W-1:0];
    if (orv == 0) begin
      res.degenerate = 1'b1;
    end else begin
      bl = bit_length(orv);
      s = 0;
      for (int i = 0; i < 3; i++) begin
        aa[i] = (bl <= 30) ? (mg[i] << (30 - bl)) : (mg[i] >> (bl - 30));
        s += aa[i] * aa[i];
      end
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = (aa[i] * 32768 + len) / (2 * len);
        if (cr[i] < 0) q = -q;
        if (i == 0) res.normal_x = q[NORM_W-1:0];
        else if (i == 1) res.normal_y = q[NORM_W-1:0];
        else res.normal_z = q[NORM_W-1:0];
      end
    end
    res.tex_u = tex_coord(col, nc + set_wrap_c);
    res.tex_v = tex_coord(row, nr + set_wrap_r);
    return 1'b1;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t %s: got %0h expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_cells.size() == 0) begin
        report("unexpected result", out_item, 0);
      end else begin
        want = pending_cells.pop_front();
        if (out_item.out_x !== want.out_x) report("out_x", out_item.out_x, want.out_x);
        if (out_item.out_y !== want.out_y) report("out_y", out_item.out_y, want.out_y);
        if (out_item.out_z !== want.out_z) report("out_z", out_item.out_z, want.out_z);
        if (out_item.normal_x !== want.normal_x)
          report("normal_x", out_item.normal_x, want.normal_x);
        if (out_item.normal_y !== want.normal_y)
          report("normal_y", out_item.normal_y, want.normal_y);
        if (out_item.normal_z !== want.normal_z)
          report("normal_z", out_item.normal_z, want.normal_z);
        if (out_item.tex_u !== want.tex_u) report("tex_u", out_item.tex_u, want.tex_u);
        if (out_item.tex_v !== want.tex_v) report("tex_v", out_item.tex_v, want.tex_v);
        if (out_item.degenerate !== want.degenerate)
          report("degenerate", out_item.degenerate, want.degenerate);
      end
    end
  end

  task automatic send_item(in_item_t item);
    out_item_t res;
    in_item <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (item.kind == KIND_LOAD) begin
      if (item.row < GRID && item.col < GRID) begin
        grid_x[item.row][item.col] = longint'(item.pos_x);
        grid_y[item.row][item.col] = longint'(item.pos_y);
        grid_z[item.row][item.col] = longint'(item.pos_z);
      end
    end else if (mesh_cell(item.row, item.col, res)) begin
      pending_cells.push_back(res);
    end
  endtask

  task automatic pause_input(bit allow_gap);
    int n;
    n = 0;
    if (allow_gap) begin
      if ($urandom_range(0, 19) == 0) n = $urandom_range(20, 300);
      else if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_point(int r, int c, bit gaps);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.row = r;
    it.col = c;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    send_item(it);
    pause_input(gaps);
  endtask

  task automatic query_cell(int r, int c, bit gaps);
    in_item_t it;
    it = '0;
    it.kind = KIND_QUERY;
    it.row = r;
    it.col = c;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    send_item(it);
    pause_input(gaps);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROWS:   set_rows = value;
      CFG_COLS:   set_cols = value;
      CFG_WRAP_C: set_wrap_c = value[0];
      default:    set_wrap_r = value[0];
    endcase
  endtask

  task automatic set_mesh(int r, int c, bit wc, bit wr);
    drain();
    cfg_write(CFG_ROWS, r);
    cfg_write(CFG_COLS, c);
    cfg_write(CFG_WRAP_C, wc);
    cfg_write(CFG_WRAP_R, wr);
  endtask

  task automatic test_fill_grid();
    for (int r = 0; r < GRID; r++)
      for (int c = 0; c < GRID; c++)
        load_point(r, c, 1'b0);
  endtask

  task automatic test_edges();
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.pos_x = 24'h7FFFFF;
    it.pos_y = 24'h800000;
    it.pos_z = 24'h7FFFFF;
    send_item(it);
    it.row = 1;
    it.pos_x = 24'h800000;
    it.pos_y = 24'h7FFFFF;
    it.pos_z = 24'h800000;
    send_item(it);
    it.row = 0;
    it.col = 1;
    it.pos_z = 24'h7FFFFF;
    send_item(it);
    query_cell(0, 0, 1'b1);
    query_cell(1, 0, 1'b1);
    query_cell(0, 1, 1'b1);
    query_cell(63, 63, 1'b1);
    query_cell(0, 63, 1'b1);
    query_cell(63, 0, 1'b1);
    query_cell(31, 17, 1'b1);
  endtask

  task automatic test_out_of_range();
    load_point(64, 3, 1'b1);
    load_point(5, 64, 1'b1);
    load_point(127, 127, 1'b1);
    query_cell(64, 0, 1'b1);
    query_cell(0, 64, 1'b1);
    query_cell(127, 127, 1'b1);
  endtask

  task automatic test_wrap();
    set_mesh(64, 64, 1'b1, 1'b1);
    query_cell(64, 64, 1'b1);
    query_cell(64, 0, 1'b1);
    query_cell(0, 64, 1'b1);
    query_cell(0, 0, 1'b1);
    query_cell(63, 63, 1'b1);
    set_mesh(5, 9, 1'b1, 1'b0);
    query_cell(4, 9, 1'b1);
    query_cell(5, 0, 1'b1);
    query_cell(2, 8, 1'b1);
  endtask

  task automatic test_degenerate();
    set_mesh(1, 1, 1'b0, 1'b0);
    query_cell(0, 0, 1'b1);
    set_mesh(1, 8, 1'b0, 1'b1);
    query_cell(1, 3, 1'b1);
    query_cell(0, 7, 1'b1);
    set_mesh(0, 127, 1'b1, 1'b1);
    query_cell(1, 1, 1'b1);
    query_cell(0, 64, 1'b1);
  endtask

  task automatic test_random();
    int r, c, wc, wr, lim_r, lim_c;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: begin r = 64; c = 64; end
        1: begin r = 1; c = $urandom_range(1, 64); end
        2: begin r = $urandom_range(0, 127); c = $urandom_range(0, 127); end
        default: begin r = $urandom_range(1, 12); c = $urandom_range(1, 12); end
      endcase
      wc = $urandom_range(0, 1);
      wr = $urandom_range(0, 1);
      set_mesh(r, c, wc, wr);
      lim_r = clamp_count(r) + 1;
      lim_c = clamp_count(c) + 1;
      for (int k = 0; k < 200; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: load_point($urandom_range(0, lim_r - 1), $urandom_range(0, lim_c - 1), 1'b1);
          3: begin
            if ($urandom_range(0, 1)) load_point($urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
            else query_cell($urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
          end
          default: query_cell($urandom_range(0, lim_r), $urandom_range(0, lim_c), 1'b1);
        endcase
      end
    end
  endtask

  initial begin
    errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    set_rows = 64;
    set_cols = 64;
    set_wrap_c = 1'b0;
    set_wrap_r = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_grid();
    test_edges();
    test_out_of_range();
    test_wrap();
    test_degenerate();
    test_random();
    drain();
    if (errors == 0) begin
      $display("grid_mesh_normal_texcoord: match");
    end else begin
      $display("grid_mesh_normal_texcoord: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
sv/gmn_pkg.sv
sv/grid_mesh_normal_texcoord.sv
sv/gmn_checker.sv
tb/grid_mesh_normal_texcoord_test.sv
